// ===== rtl/core/djb2dr_pkg.sv =====
`timescale 1ns / 1ps

package djb2dr_pkg;

  // Password length and the number of character fields on the result port
  localparam int PASS_CHARS = 6;
  localparam int NUM_OUT    = 6;

  // Rounds whose character reaches the result port
  localparam int NUM_DIG    = (PASS_CHARS < NUM_OUT) ? PASS_CHARS : NUM_OUT;

  localparam int DIGIT_W    = 6;
  localparam int HASH_W     = 64;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [7:0]         char_t;
  typedef logic [HASH_W-1:0]  hash_t;

  localparam hash_t  DJB_SEED = 64'd5381;
  localparam digit_t OFFS_MUL = 6'd61;

  // Reduction request: the six-bit digits of the folded hash above the
  // lowest one, and the per-step offset
  typedef struct packed {
    logic [NUM_DIG*DIGIT_W-1:0] digits;
    digit_t                     offs;
  } red_req_t;

  // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic char_t b64_char(input digit_t v);
    char_t c;
    if (v < 6'd26) begin
      c = 8'(v) + 8'd65;
    end else if (v < 6'd52) begin
      c = 8'(v) + 8'd71;
    end else if (v < 6'd62) begin
      c = 8'(v) - 8'd4;
    end else if (v == 6'd62) begin
      c = 8'd43;
    end else begin
      c = 8'd47;
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/djb2dr_fold.sv =====
`timescale 1ns / 1ps

module djb2dr_fold (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           data_byte,
  input  logic                 last,
  output djb2dr_pkg::hash_t    acc
);
  import djb2dr_pkg::*;

  hash_t hash_r;
  hash_t hash_nxt;

  // hash * 33 plus the byte taken as a signed char, wrapping at 64 bits
  assign acc = (hash_r << 5) + hash_r + {{(HASH_W-8){data_byte[7]}}, data_byte};

  // Return to the seed once a message closes
  assign hash_nxt = last ? DJB_SEED : acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= DJB_SEED;
    end else if (take) begin
      hash_r <= hash_nxt;
    end
  end

endmodule

// ===== rtl/core/djb2dr_reduce.sv =====
`timescale 1ns / 1ps

module djb2dr_reduce (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  output logic                  load_ready,
  input  djb2dr_pkg::red_req_t  load_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output djb2dr_pkg::char_t     chars [djb2dr_pkg::NUM_OUT]
);
  import djb2dr_pkg::*;

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  red_req_t s1_req_r;
  logic     s1_adv;
  logic     out_valid_r;
  logic     out_valid_nxt;
  char_t    chars_r   [NUM_OUT];
  char_t    chars_nxt [NUM_OUT];

  // Advance the held request when the result register is free or drains
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_ready);
  assign load_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load_valid && load_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Each round's low digit is the next hash digit plus offset plus the
  // carry out of the previous round; only that one carry crosses rounds
  always_comb begin
    logic [DIGIT_W:0] sum;
    logic             carry;
    carry = 1'b0;
    sum   = '0;
    for (int k = 0; k < NUM_OUT; k++) begin
      if (k < NUM_DIG) begin
        sum = {1'b0, s1_req_r.digits[k*DIGIT_W +: DIGIT_W]}
            + {1'b0, s1_req_r.offs} + {{DIGIT_W{1'b0}}, carry};
        chars_nxt[k] = b64_char(sum[DIGIT_W-1:0]);
        carry = sum[DIGIT_W];
      end else begin
        chars_nxt[k] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      s1_req_r <= load_req;
    end
    if (s1_adv) begin
      chars_r <= chars_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign chars     = chars_r;

endmodule

// ===== rtl/core/djb2_digest_reduction_top.sv =====
`timescale 1ns / 1ps
// Result: a last_byte request loads the reduction stage, then the result register once
//   that is free or drains. Throughput: one request per cycle while in_ready is high;
//   the 64-bit shift-add fold and the six-round digit carry chain are combinational.
// Reset: rst_n is synchronous, active low; it loads the hash with 5381 and empties
//   the reduction stage and the result register.
module djb2_digest_reduction_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_digest_byte,
  input  logic [31:0] in_step_index,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char_0,
  output logic [7:0]  out_char_1,
  output logic [7:0]  out_char_2,
  output logic [7:0]  out_char_3,
  output logic [7:0]  out_char_4,
  output logic [7:0]  out_char_5
);
  import djb2dr_pkg::*;

  logic     take;
  logic     load_valid;
  logic     load_ready;
  hash_t    acc;
  red_req_t load_req;
  char_t    chars [NUM_OUT];

  // Every request folds into the hash; hold all requests while the
  // reduction stage is full and cannot drain, so the hash never runs ahead
  assign in_ready   = load_ready;
  assign take       = in_valid && in_ready;
  assign load_valid = take && in_last_byte;

  djb2dr_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_digest_byte),
    .last      (in_last_byte),
    .acc       (acc)
  );

  // Drop the lowest digit: the hash is sliced above it. Only the step
  // index mod 64 matters, so a 6-bit product gives the offset.
  assign load_req.digits = acc[DIGIT_W +: NUM_DIG*DIGIT_W];
  assign load_req.offs   = digit_t'(in_step_index[DIGIT_W-1:0] * OFFS_MUL);

  djb2dr_reduce u_reduce (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_ready (load_ready),
    .load_req   (load_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .chars      (chars)
  );

  assign out_char_0 = chars[0];
  assign out_char_1 = chars[1];
  assign out_char_2 = chars[2];
  assign out_char_3 = chars[3];
  assign out_char_4 = chars[4];
  assign out_char_5 = chars[5];

endmodule
